// ----- hdl/tte_pkg.sv -----
// ----------------------------------------------------------------------------
// tte_pkg
// Types, widths, register indexes and constants shared by the tap tempo
// estimator files.
// ----------------------------------------------------------------------------
package tte_pkg;

  localparam int unsigned ACC_W      = 16;
  localparam int unsigned TS_W       = 32;
  localparam int unsigned MAG_W      = 32;
  localparam int unsigned TARGET_W   = 6;
  localparam int unsigned HOLD_W     = 16;
  localparam int unsigned TEMPO_W    = 16;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DIV_W      = 32;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_W);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_TARGET    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAG_BASELINE  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_THRESHOLD = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF       = CFG_IDX_W'(3);

  localparam logic [TARGET_W-1:0] TAP_TARGET_RST   = TARGET_W'(10);
  localparam logic [MAG_W-1:0]    MAG_BASELINE_RST = MAG_W'(1000000);
  localparam logic [MAG_W-1:0]    TAP_THRESH_RST   = MAG_W'(180000);
  localparam logic [HOLD_W-1:0]   HOLDOFF_RST      = HOLD_W'(300);

  localparam logic [DIV_W-1:0]    TEMPO_NUM  = DIV_W'(60000);
  localparam int unsigned         TEMPO_STEP_LOG2 = 2;
  localparam logic [TEMPO_W-1:0]  TEMPO_MAX  = TEMPO_W'(60000);

  typedef struct packed {
    logic                     mode;
    logic signed [ACC_W-1:0]  accel_x;
    logic signed [ACC_W-1:0]  accel_y;
    logic signed [ACC_W-1:0]  accel_z;
    logic [TS_W-1:0]          timestamp_ms;
  } tte_in_t;

  typedef struct packed {
    logic                tap_detected;
    logic                done_res;
    logic [TEMPO_W-1:0]  tempo_bpm;
  } tte_out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } tte_cfg_req_t;

  typedef struct packed {
    logic [TARGET_W-1:0] tap_target;
    logic [MAG_W-1:0]    magnitude_baseline;
    logic [MAG_W-1:0]    tap_threshold;
    logic [HOLD_W-1:0]   holdoff_ms;
  } tte_cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } tte_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } tte_div_rsp_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } tte_core_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_CHECK,
    ST_UPDATE,
    ST_FINISH,
    ST_AVG,
    ST_TEMPO,
    ST_RESULT
  } tte_state_t;

endpackage

// ----- hdl/tte_if.sv -----
// ----------------------------------------------------------------------------
// tte_if
// Valid/ready channels of the tap tempo estimator: sample input, result
// output and configuration write.
// ----------------------------------------------------------------------------
interface tte_in_if import tte_pkg::*; ();
  logic    valid;
  logic    ready;
  tte_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tte_out_if import tte_pkg::*; ();
  logic     valid;
  logic     ready;
  tte_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tte_cfg_if import tte_pkg::*; ();
  logic         valid;
  logic         ready;
  tte_cfg_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/tte_div.sv -----
// ----------------------------------------------------------------------------
// tte_div
// Shared restoring divider: one quotient bit per cycle, done pulse after
// the last bit. Divisor must be non-zero.
// ----------------------------------------------------------------------------
module tte_div import tte_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  tte_div_req_t req,
  output tte_div_rsp_t rsp
);

  logic [DIV_W-1:0]     rem_r;
  logic [DIV_W-1:0]     quo_r;
  logic [DIV_W-1:0]     dsr_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DIV_W:0] rem_sh;
  logic [DIV_W:0] rem_sub;
  logic           ge;

  assign rem_sh  = {rem_r, quo_r[DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, dsr_r};
  assign rem_sub = rem_sh - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ----- hdl/tte_core.sv -----
// ----------------------------------------------------------------------------
// tte_core
// Sequencer and datapath: squares the axes on one multiplier, detects taps,
// accumulates intervals and drives the shared divider for the tempo.
// ----------------------------------------------------------------------------
module tte_core import tte_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  tte_in_t       item,
  input  tte_cfg_t      cfg,
  input  logic          res_ack,
  output tte_core_sts_t sts,
  output tte_out_t      res,
  output tte_div_req_t  div_req,
  input  tte_div_rsp_t  div_rsp
);

  tte_state_t state_r, state_nxt;

  // measurement state
  logic [CNT_W-1:0]   tap_counter_r;
  logic [TS_W-1:0]    last_tap_r;
  logic               have_prev_r;
  logic [TS_W-1:0]    interval_sum_r;
  logic               finished_r;
  logic [TEMPO_W-1:0] held_tempo_r;

  // per-item working registers
  tte_in_t            item_r;
  logic [1:0]         sq_cnt_r;
  logic [MAG_W-1:0]   prod_r;
  logic [MAG_W-1:0]   mag_r;
  logic [TS_W-1:0]    diff_r;
  logic               tap_r;

  logic signed [ACC_W-1:0]   sq_op;
  logic signed [2*ACC_W-1:0] sq_full;
  logic [MAG_W:0]            limit;
  logic                      above;
  logic                      later;
  logic [TS_W:0]             sum_add;
  logic [TS_W-1:0]           sum_sat;
  logic [CNT_W-1:0]          cnt_inc;
  logic                      finishing;

  always_comb begin
    unique case (sq_cnt_r)
      2'd0:    sq_op = item_r.accel_x;
      2'd1:    sq_op = item_r.accel_y;
      2'd2:    sq_op = item_r.accel_z;
      default: sq_op = '0;
    endcase
  end

  assign sq_full   = sq_op * sq_op;
  assign limit     = {1'b0, cfg.magnitude_baseline} + {1'b0, cfg.tap_threshold};
  assign above     = {1'b0, mag_r} > limit;
  assign later     = {1'b0, item_r.timestamp_ms} >
                     ({1'b0, last_tap_r} + (TS_W+1)'(cfg.holdoff_ms));
  assign sum_add   = {1'b0, interval_sum_r} + {1'b0, diff_r};
  assign sum_sat   = sum_add[TS_W] ? '1 : sum_add[TS_W-1:0];
  assign cnt_inc   = tap_counter_r + CNT_W'(1);
  assign finishing = tap_r && (cnt_inc > CNT_W'(cfg.tap_target));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    div_req.start    = 1'b0;
    div_req.dividend = interval_sum_r;
    div_req.divisor  = DIV_W'(cfg.tap_target);
    sts.idle         = 1'b0;
    sts.res_valid    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        sts.idle = 1'b1;
        if (start) begin
          state_nxt = (item.mode || finished_r) ? ST_CHECK : ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (sq_cnt_r == 2'd3) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = (item_r.mode || finished_r) ? ST_RESULT : ST_UPDATE;
      end
      ST_UPDATE: begin
        if (finishing && (cfg.tap_target != '0)) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_FINISH: begin
        div_req.start = 1'b1;
        state_nxt     = ST_AVG;
      end
      ST_AVG: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient == '0) begin
            state_nxt = ST_RESULT;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = TEMPO_NUM;
            div_req.divisor  = div_rsp.quotient;
            state_nxt        = ST_TEMPO;
          end
        end
      end
      ST_TEMPO: begin
        if (div_rsp.done) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        sts.res_valid = 1'b1;
        if (res_ack) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // measurement state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_counter_r  <= '0;
      last_tap_r     <= '0;
      have_prev_r    <= 1'b0;
      interval_sum_r <= '0;
      finished_r     <= 1'b0;
      held_tempo_r   <= '0;
    end else begin
      unique case (state_r)
        ST_CHECK: begin
          // restart clears the whole measurement
          if (item_r.mode) begin
            tap_counter_r  <= '0;
            last_tap_r     <= '0;
            have_prev_r    <= 1'b0;
            interval_sum_r <= '0;
            finished_r     <= 1'b0;
            held_tempo_r   <= '0;
          end
        end
        ST_UPDATE: begin
          if (tap_r) begin
            tap_counter_r <= cnt_inc;
            last_tap_r    <= item_r.timestamp_ms;
            have_prev_r   <= 1'b1;
            if (have_prev_r) begin
              interval_sum_r <= sum_sat;
            end
            if (finishing && (cfg.tap_target == '0)) begin
              held_tempo_r <= '0;
              finished_r   <= 1'b1;
            end
          end
        end
        ST_AVG: begin
          if (div_rsp.done && (div_rsp.quotient == '0)) begin
            held_tempo_r <= '0;
            finished_r   <= 1'b1;
          end
        end
        ST_TEMPO: begin
          // round down to a multiple of four
          if (div_rsp.done) begin
            held_tempo_r <= {div_rsp.quotient[TEMPO_W-1:TEMPO_STEP_LOG2],
                             TEMPO_STEP_LOG2'(0)};
            finished_r   <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      item_r   <= item;
      sq_cnt_r <= '0;
      mag_r    <= '0;
      tap_r    <= 1'b0;
    end
    if (state_r == ST_SQUARE) begin
      sq_cnt_r <= sq_cnt_r + 2'd1;
      prod_r   <= MAG_W'(unsigned'(sq_full));
      if (sq_cnt_r != 2'd0) begin
        mag_r <= mag_r + prod_r;
      end
    end
    if (state_r == ST_CHECK) begin
      tap_r  <= !item_r.mode && !finished_r && above && (!have_prev_r || later);
      diff_r <= item_r.timestamp_ms - last_tap_r;
    end
  end

  assign res.tap_detected = tap_r;
  assign res.done_res     = finished_r;
  assign res.tempo_bpm    = held_tempo_r;

endmodule

// ----- hdl/accel_tap_tempo_estimator_unit.sv -----
// ----------------------------------------------------------------------------
// accel_tap_tempo_estimator_unit
// Tap tempo estimator top level: configuration registers, sample intake,
// result register.
// ----------------------------------------------------------------------------
// One request at a time: a sample is accepted only while the sequencer is
// idle. An ordinary sample has its axes squared on the shared squaring
// multiplier, then passes tap check and state update; a restart or a sample
// arriving after the tempo is held goes from tap check straight to result.
// For a non-zero tap target, the sample that completes the measurement also
// runs the shared restoring divider for the average interval, then, if that
// is non-zero, for 60000 / average. The next sample is taken as soon as the
// sequencer returns to idle, even while the previous result still waits in
// the output register. Configuration writes are always accepted and take
// effect on the next sample; write them only while no sample is in flight.
module accel_tap_tempo_estimator_unit import tte_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  tte_in_if.sink    in_if,
  tte_out_if.source out_if,
  tte_cfg_if.sink   cfg_if
);

  tte_cfg_t      cfg_r;
  tte_core_sts_t sts;
  tte_out_t      res;
  tte_div_req_t  div_req;
  tte_div_rsp_t  div_rsp;
  logic          start;
  logic          res_ack;
  logic          out_valid_r;
  tte_out_t      out_data_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tap_target         <= TAP_TARGET_RST;
      cfg_r.magnitude_baseline <= MAG_BASELINE_RST;
      cfg_r.tap_threshold      <= TAP_THRESH_RST;
      cfg_r.holdoff_ms         <= HOLDOFF_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.data.index)
        CFG_TAP_TARGET:    cfg_r.tap_target         <= cfg_if.data.wdata[TARGET_W-1:0];
        CFG_MAG_BASELINE:  cfg_r.magnitude_baseline <= cfg_if.data.wdata[MAG_W-1:0];
        CFG_TAP_THRESHOLD: cfg_r.tap_threshold      <= cfg_if.data.wdata[MAG_W-1:0];
        CFG_HOLDOFF:       cfg_r.holdoff_ms         <= cfg_if.data.wdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_if.ready = sts.idle;
  assign start       = in_if.valid && sts.idle;

  // load the result register when it is empty or being drained
  assign res_ack = sts.res_valid && (!out_valid_r || out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ack) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      out_data_r <= res;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  tte_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .item    (in_if.data),
    .cfg     (cfg_r),
    .res_ack (res_ack),
    .sts     (sts),
    .res     (res),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  tte_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule

// ----- hdl/tte_chk.sv -----
// ----------------------------------------------------------------------------
// tte_chk
// Port-level checks for the tap tempo estimator, bound to the top level.
// ----------------------------------------------------------------------------
module tte_chk import tte_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input tte_out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one request at a time: busy right after an accept
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready straight after accept");

  a_tempo_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.tempo_bpm[TEMPO_STEP_LOG2-1:0] == '0)
    else $error("tempo not a multiple of four");

  a_tempo_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.done_res |-> out_data.tempo_bpm == '0)
    else $error("tempo shown before measurement done");

  a_tempo_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.tempo_bpm <= TEMPO_MAX)
    else $error("tempo out of range");

endmodule

bind accel_tap_tempo_estimator_unit tte_chk u_tte_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.data)
);
